// ===== rtl/core/smt_pkg.sv =====
package smt_pkg;

  // default sizes of the table
  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // port field widths
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 16;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_COUNT  = 2'd1,
    KIND_GET    = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_PAST_END = 2'd2
  } status_t;

  // per-cell update command
  typedef struct packed {
    logic load;
    logic shift;
    logic bump;
  } cell_cmd_t;

endpackage

// ===== rtl/core/smt_if.sv =====
interface smt_in_if import smt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  position;

  modport source (output valid, kind, key, position, input ready);
  modport sink   (input valid, kind, key, position, output ready);
endinterface

interface smt_out_if import smt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  index;
  logic [COUNT_W-1:0]  count;
  logic [KEY_W-1:0]    key_out;

  modport source (output valid, status, index, count, key_out, input ready);
  modport sink   (input valid, status, index, count, key_out, output ready);
endinterface

// ===== rtl/core/smt_cell.sv =====
module smt_cell import smt_pkg::*; #(
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   compare_signed,
  input  logic [KEY_WIDTH-1:0]   key_new,
  input  logic [KEY_WIDTH-1:0]   key_order,
  input  cell_cmd_t              cmd,
  input  logic [KEY_WIDTH-1:0]   prev_key,
  input  logic [COUNT_WIDTH-1:0] prev_count,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [COUNT_WIDTH-1:0] count,
  output logic                   ge,
  output logic                   eq
);

  logic [KEY_WIDTH-1:0] sign_mask;
  logic [KEY_WIDTH-1:0] own_order;

  // flip the sign bit so an unsigned compare gives the configured order
  assign sign_mask = KEY_WIDTH'(compare_signed) << (KEY_WIDTH - 1);
  assign own_order = key ^ sign_mask;
  assign ge        = own_order >= key_order;
  assign eq        = own_order == key_order;

  // entry storage: new key, shift from the lower neighbor, or count bump
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= key_new;
      count <= COUNT_WIDTH'(1);
    end else if (cmd.shift) begin
      key   <= prev_key;
      count <= prev_count;
    end else if (cmd.bump && (count != '1)) begin
      count <= count + 1'b1;
    end
  end

endmodule

// ===== rtl/core/smt_scan.sv =====
module smt_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] x,
  output logic [N-1:0] below
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LEVELS+1];

  // log-depth prefix or: lvl[LEVELS][i] is the or of x[0..i]
  always_comb begin
    lvl[0] = x;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  // exclusive form: or of all lower positions
  always_comb begin
    below[0] = 1'b0;
    for (int i = 1; i < N; i++) begin
      below[i] = lvl[LEVELS][i-1];
    end
  end

endmodule

// ===== rtl/core/sorted_multiset_table_unit.sv =====
// Sorted table of up to CAPACITY distinct keys with saturating repeat counts.
// Every entry lives in its own cell with a key comparator, so insert, count
// query and get each act on all cells at once: one item is taken per clock
// while the result register is free or being drained, and its result is
// registered at the accepting edge. The rate is set by the per-cell compare,
// the log-depth priority scan across the row and the one-step shift of each
// cell from its lower neighbor. compare_signed selects unsigned or two's
// complement ordering; the user must write it only while the block is idle,
// which the block does not enforce; there is no clearing pass after reset.
module sorted_multiset_table_unit import smt_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  smt_in_if.sink     req,
  smt_out_if.source  rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  logic                   compare_signed;
  logic [OW-1:0]          occupancy;
  logic [OW-1:0]          occupancy_next;

  logic                   fire;
  kind_t                  kind;
  logic [63:0]            key_ext;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [KEY_WIDTH-1:0]   sign_mask;
  logic [KEY_WIDTH-1:0]   key_order;
  logic [31:0]            pos32;
  logic [31:0]            occ32;

  logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
  logic [COUNT_WIDTH-1:0] cell_count [CAPACITY];
  cell_cmd_t              cell_cmd   [CAPACITY];
  logic [CAPACITY-1:0]    ge;
  logic [CAPACITY-1:0]    eq;
  logic [CAPACITY-1:0]    valid;
  logic [CAPACITY-1:0]    ge_valid;
  logic [CAPACITY-1:0]    eq_valid;
  logic [CAPACITY-1:0]    ge_below;
  logic [CAPACITY-1:0]    eq_below;
  logic [CAPACITY-1:0]    first_ge;
  logic [CAPACITY-1:0]    first_eq;
  logic [CAPACITY-1:0]    at_or_after;
  logic [CAPACITY-1:0]    load_vec;

  logic                   found;
  logic                   full;
  logic                   do_insert;
  logic                   do_bump;
  logic [IW-1:0]          target;
  logic [COUNT_WIDTH-1:0] count_sel;
  logic [KEY_WIDTH-1:0]   get_key;
  logic [31:0]            target32;
  logic [31:0]            count32;
  logic [63:0]            key64;

  // handshake: a new beat is taken whenever the result register frees up
  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign kind      = kind_t'(req.kind);

  // search key in table width and in compare order
  assign key_ext   = {32'b0, req.key};
  assign key_in    = key_ext[KEY_WIDTH-1:0];
  assign sign_mask = KEY_WIDTH'(compare_signed) << (KEY_WIDTH - 1);
  assign key_order = key_in ^ sign_mask;
  assign pos32     = 32'(req.position);
  assign occ32     = 32'(occupancy);
  assign full      = occ32 == 32'(CAPACITY);

  // entries below the fill level hold data
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = occ32 > 32'(i);
    end
  end

  assign ge_valid = ge & valid;
  assign eq_valid = eq & valid;

  smt_scan #(.N(CAPACITY)) u_scan_ge (.x(ge_valid), .below(ge_below));
  smt_scan #(.N(CAPACITY)) u_scan_eq (.x(eq_valid), .below(eq_below));

  // first entry not below the key, and first equal entry
  assign first_ge    = ge_valid & ~ge_below;
  assign first_eq    = eq_valid & ~eq_below;
  assign at_or_after = ge_valid | ge_below | ~valid;
  assign load_vec    = at_or_after & ~(at_or_after << 1);
  assign found       = |(first_ge & eq);

  assign do_insert = fire && (kind == KIND_INSERT) && !found && !full;
  assign do_bump   = fire && (kind == KIND_INSERT) && found;

  // row of cells, each fed by its lower neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      cell_cmd[g].load  = do_insert && load_vec[g];
      cell_cmd[g].shift = (g > 0) ? (do_insert && at_or_after[(g > 0) ? g - 1 : 0]) : 1'b0;
      cell_cmd[g].bump  = do_bump && first_ge[g];
    end

    smt_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk           (clk),
      .compare_signed(compare_signed),
      .key_new       (key_in),
      .key_order     (key_order),
      .cmd           (cell_cmd[g]),
      .prev_key      (cell_key[(g > 0) ? g - 1 : 0]),
      .prev_count    (cell_count[(g > 0) ? g - 1 : 0]),
      .key           (cell_key[g]),
      .count         (cell_count[g]),
      .ge            (ge[g]),
      .eq            (eq[g])
    );
  end

  // encode target position and gather query and get data
  always_comb begin
    target    = '0;
    count_sel = '0;
    get_key   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (load_vec[i]) begin
        target = target | IW'(i);
      end
      if (first_eq[i]) begin
        count_sel = count_sel | cell_count[i];
      end
      if (valid[i] && (pos32 == 32'(i))) begin
        get_key = get_key | cell_key[i];
      end
    end
  end

  assign target32 = 32'(target);
  assign count32  = 32'(count_sel);
  assign key64    = 64'(get_key);

  // fill level
  always_comb begin
    occupancy_next = occupancy;
    if (do_insert) begin
      occupancy_next = occupancy + 1'b1;
    end
  end

  // config register, fill level and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      compare_signed <= 1'b0;
      occupancy      <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        compare_signed <= cfg_wdata;
      end
      occupancy <= occupancy_next;
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status  <= ST_OK;
      rsp.index   <= '0;
      rsp.count   <= '0;
      rsp.key_out <= '0;
      case (kind)
        KIND_INSERT: begin
          if (found || !full) begin
            rsp.index <= target32[INDEX_W-1:0];
          end else begin
            rsp.status <= ST_FULL;
          end
        end
        KIND_COUNT: begin
          rsp.count <= count32[COUNT_W-1:0];
        end
        KIND_GET: begin
          if (pos32 < occ32) begin
            rsp.key_out <= key64[KEY_W-1:0];
          end else begin
            rsp.status <= ST_PAST_END;
          end
        end
        default: begin
          rsp.status <= ST_OK;
        end
      endcase
    end
  end

  // fill level stays within the row
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ32 <= 32'(CAPACITY))
    else $error("occupancy beyond capacity");

  // at most one cell can take the new key
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0(load_vec))
    else $error("more than one insert point");

  // a new-key insert grows the table by exactly one entry
  a_occ_grow: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (occupancy == $past(occupancy) + 1'b1))
    else $error("occupancy did not grow on insert");

  // a matched key never also opens a new slot
  a_bump_no_grow: assert property (@(posedge clk) disable iff (rst)
    do_bump |=> (occupancy == $past(occupancy)))
    else $error("occupancy changed on count bump");

endmodule

// ===== dv/sorted_multiset_table_checker.sv =====
module sorted_multiset_table_checker import smt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  smt_in_if    req,
  smt_out_if   rsp,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   full_drops,
  output int   past_end_gets
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 SLOTS      = CAPACITY_DEF;
  localparam logic [COUNT_W-1:0] COUNT_CEIL = '1;
  localparam logic [KEY_W-1:0]   SIGN_FLIP  = {1'b1, {(KEY_W-1){1'b0}}};

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [COUNT_W-1:0]  count;
    logic [KEY_W-1:0]    key_out;
  } table_rsp_t;

  // shadow copy of the table contents and ordering mode
  logic [KEY_W-1:0]   key_tab [SLOTS];
  logic [COUNT_W-1:0] cnt_tab [SLOTS];
  int                 fill;
  logic               signed_order;
  table_rsp_t         owed_answers [$];

  // maps a key to a value whose unsigned order is the selected key order
  function automatic logic [KEY_W-1:0] rank_of(input logic [KEY_W-1:0] k);
    return signed_order ? (k ^ SIGN_FLIP) : k;
  endfunction

  // applies one request to the shadow table and returns its answer
  function automatic table_rsp_t apply_table_op(input logic [KIND_W-1:0] kind,
                                                input logic [KEY_W-1:0] key,
                                                input logic [POS_W-1:0] pos);
    table_rsp_t ans;
    int         slot;
    bit         hit;
    ans  = '0;
    slot = fill;
    hit  = 1'b0;
    case (kind)
      KIND_INSERT: begin
        // first entry not below the key decides between bump and placement
        for (int i = 0; i < fill; i++) begin
          if (rank_of(key_tab[i]) >= rank_of(key)) begin
            slot = i;
            hit  = (key_tab[i] == key);
            break;
          end
        end
        if (hit) begin
          if (cnt_tab[slot] != COUNT_CEIL) cnt_tab[slot] = cnt_tab[slot] + 1'b1;
          ans.index = INDEX_W'(slot);
        end else if (fill >= SLOTS) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = fill; i > slot; i--) begin
            key_tab[i] = key_tab[i-1];
            cnt_tab[i] = cnt_tab[i-1];
          end
          key_tab[slot] = key;
          cnt_tab[slot] = COUNT_W'(1);
          fill++;
          ans.index = INDEX_W'(slot);
        end
      end
      KIND_COUNT: begin
        for (int i = 0; i < fill; i++) begin
          if (key_tab[i] == key) begin
            ans.count = cnt_tab[i];
            break;
          end
        end
      end
      KIND_GET: begin
        if (pos < fill) ans.key_out = key_tab[pos];
        else ans.status = ST_PAST_END;
      end
      default: begin
        // spare kind leaves the table alone and answers all zero
      end
    endcase
    return ans;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
    end
  endtask

  // predict on request beats, compare on response beats
  always @(posedge clk) begin : watch
    table_rsp_t want;
    if (rst) begin
      fill         = 0;
      signed_order = 1'b0;
      owed_answers.delete();
      errors        = 0;
      checked       = 0;
      full_drops    = 0;
      past_end_gets = 0;
    end else begin
      if (cfg_we) signed_order = cfg_wdata;
      if (req.valid && req.ready) begin
        want = apply_table_op(req.kind, req.key, req.position);
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_PAST_END) past_end_gets++;
        owed_answers.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_answers.size() == 0) begin
          errors++;
          $display("%0t: response beat with none expected, actual status=%0d index=%0d",
                   $time, rsp.status, rsp.index);
          $display("%0t:   actual count=%0d key_out=0x%0h", $time, rsp.count, rsp.key_out);
        end else begin
          want = owed_answers.pop_front();
          checked++;
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("index", 32'(want.index), 32'(rsp.index));
          check_field("count", 32'(want.count), 32'(rsp.count));
          check_field("key_out", want.key_out, rsp.key_out);
        end
      end
    end
    pending <= owed_answers.size();
  end

endmodule

// ===== dv/sorted_multiset_table_unit_test.sv =====
module sorted_multiset_table_unit_test import smt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_SPARE     = 2'd3;
  localparam logic              ORDER_UNSIGNED = 1'b0;
  localparam logic              ORDER_SIGNED   = 1'b1;
  localparam logic [KEY_W-1:0]  SAT_KEY        = 32'h1234_5678;
  localparam int                SAT_BEATS      = 40;
  localparam int                RANDOM_BEATS   = 350;
  localparam int                QUIET_LIMIT    = 2000;
  localparam int                DRAIN_SLACK    = 6;
  localparam int                POOL_MAX       = 256;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  smt_in_if  req_ch ();
  smt_out_if rsp_ch ();

  int errors;
  int pending;
  int checked;
  int full_drops;
  int past_end_gets;

  int               beats_sent  = 0;
  int               quiet_cycles = 0;
  logic             src_idle    = 1'b0;
  logic             sink_stall  = 1'b0;
  logic [KEY_W-1:0] key_pool [$];

  sorted_multiset_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  sorted_multiset_table_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .full_drops    (full_drops),
    .past_end_gets (past_end_gets)
  );

  always #5ns clk = ~clk;

  // gap lengths: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 1;
    if (r < 85) return $urandom_range(4, 2);
    if (r < 97) return $urandom_range(12, 5);
    return $urandom_range(60, 20);
  endfunction

  // keys that sit on the signed and unsigned order boundaries
  function automatic logic [KEY_W-1:0] boundary_key(input int sel);
    case (sel)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFE;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'h8000_0001;
      6:       return 32'hFFFF_FFFE;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // reuse earlier keys often so bumps and hits dominate
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 60 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 75) return boundary_key($urandom_range(7));
    return $urandom();
  endfunction

  // wait until every predicted answer has come back, then a little more
  task automatic drain_results();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_order(input logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stop sending, let the block go idle, then change the key order
  task automatic reorder(input logic mode);
    req_ch.valid <= 1'b0;
    drain_results();
    write_order(mode);
  endtask

  // one request beat, followed by an optional gap or full drain
  task automatic send_req(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] key_v,
                          input logic [POS_W-1:0] pos_v);
    int gap;
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= k;
    req_ch.key      <= key_v;
    req_ch.position <= pos_v;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    beats_sent++;
    if (src_idle && $urandom_range(299) == 0) begin
      req_ch.valid <= 1'b0;
      drain_results();
    end else if (src_idle && $urandom_range(99) < 35) begin
      gap = pick_gap();
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= KIND_W'($urandom());
      req_ch.key      <= $urandom();
      req_ch.position <= POS_W'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_beat();
    int               r;
    logic [KIND_W-1:0] k;
    logic [KEY_W-1:0]  key_v;
    r = $urandom_range(99);
    if (r < 40) k = KIND_INSERT;
    else if (r < 70) k = KIND_COUNT;
    else if (r < 95) k = KIND_GET;
    else k = KIND_SPARE;
    key_v = pick_key();
    if (k == KIND_INSERT && key_pool.size() < POOL_MAX) key_pool.push_back(key_v);
    send_req(k, key_v, POS_W'($urandom()));
  endtask

  // random traffic under one key order, idling style reshuffled every 100 beats
  task automatic run_phase(input logic mode);
    int r;
    reorder(mode);
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 100 == 0) begin
        r          = $urandom_range(3);
        src_idle   = r[0];
        sink_stall = r[1];
      end
      random_beat();
    end
  endtask

  // response side backpressure
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (sink_stall && $urandom_range(99) < 30) hold_left = pick_gap();
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_INSERT;
    req_ch.key      <= '0;
    req_ch.position <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_order(ORDER_UNSIGNED);

    // directed: empty table, spare kind, boundary keys, bump, gets in and past range
    src_idle   = 1'b1;
    sink_stall = 1'b1;
    send_req(KIND_GET, '0, 6'd0);
    send_req(KIND_COUNT, 32'hFFFF_FFFF, '0);
    send_req(KIND_SPARE, 32'hFFFF_FFFF, 6'd63);
    send_req(KIND_INSERT, 32'h8000_0000, '0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, '0);
    send_req(KIND_INSERT, 32'h0000_0000, '0);
    send_req(KIND_INSERT, 32'h7FFF_FFFF, '0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, '0);
    send_req(KIND_COUNT, 32'hFFFF_FFFF, '0);
    send_req(KIND_COUNT, 32'h0000_0000, '0);
    for (int p = 0; p < 4; p++) send_req(KIND_GET, '0, POS_W'(p));
    send_req(KIND_GET, '0, 6'd4);
    send_req(KIND_GET, '0, 6'd63);
    send_req(KIND_COUNT, 32'h0000_0001, 6'd63);

    // directed: signed order with negative keys
    reorder(ORDER_SIGNED);
    send_req(KIND_INSERT, 32'hFFFF_FFFE, '0);
    send_req(KIND_COUNT, 32'h8000_0000, '0);
    send_req(KIND_GET, '0, 6'd0);

    // hammer one key back to back to grow its count, no idling
    src_idle   = 1'b0;
    sink_stall = 1'b0;
    repeat (SAT_BEATS) send_req(KIND_INSERT, SAT_KEY, '0);
    send_req(KIND_COUNT, SAT_KEY, '0);

    // random phases, alternating key order; the table fills along the way
    run_phase(ORDER_UNSIGNED);
    run_phase(ORDER_SIGNED);
    run_phase(ORDER_UNSIGNED);
    run_phase(ORDER_SIGNED);

    req_ch.valid <= 1'b0;
    drain_results();
    $display("%0d request beats sent (repeated-key run included), %0d responses checked",
             beats_sent, checked);
    $display("%0d inserts dropped on a full table, %0d gets past the end, both key orders",
             full_drops, past_end_gets);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
